>>> src/ptb_pkg.sv
package ptb_pkg;

   // Pool geometry (POOL_PAGES is a power of two)
   localparam int POOL_PAGES = 16;
   localparam int PAGE_BITS  = $clog2(POOL_PAGES);
   localparam int IDX_BITS   = 9;
   localparam int ADDR_BITS  = PAGE_BITS + IDX_BITS;
   localparam int DEPTH      = POOL_PAGES * 512;
   localparam int WORD_BITS  = 64;
   localparam int FRAME_BITS = 40;
   localparam int FLAG_BITS  = 12;
   localparam int PAGE_SHIFT = 12;
   localparam int USED_BITS  = $clog2(POOL_PAGES + 1);
   localparam int SUM_BITS   = ((USED_BITS > 5) ? USED_BITS : 5) + 1;

   // Request operations; the last code has no effect
   localparam logic [1:0] OP_SET    = 2'd0;
   localparam logic [1:0] OP_MAP    = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_FLAGS = 2'd0;
   localparam logic [1:0] CSR_BASE  = 2'd1;
   localparam logic [1:0] CSR_LIMIT = 2'd2;

   typedef struct packed {
      logic [IDX_BITS-1:0] top;
      logic [IDX_BITS-1:0] dir_ptr;
      logic [IDX_BITS-1:0] dir;
      logic [IDX_BITS-1:0] leaf;
   } cursor_type;

   typedef struct packed {
      logic load;
      logic advance;
   } cursor_cmd_type;

endpackage

>>> src/ptb_ram.sv
module ptb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

>>> src/ptb_cursor.sv
module ptb_cursor import ptb_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cursor_cmd_type cmd,
   input  cursor_type     load_value,
   output cursor_type     cursor
);

   cursor_type cur_ff, cur_in;

   // Load, or advance with carries; top index wraps
   always_comb begin
      cur_in = cur_ff;
      if (cmd.load) begin
         cur_in = load_value;
      end else if (cmd.advance) begin
         cur_in.leaf = cur_ff.leaf + 1'b1;
         if (&cur_ff.leaf) begin
            cur_in.dir = cur_ff.dir + 1'b1;
            if (&cur_ff.dir) begin
               cur_in.dir_ptr = cur_ff.dir_ptr + 1'b1;
               if (&cur_ff.dir_ptr) begin
                  cur_in.top = cur_ff.top + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else begin
         cur_ff <= cur_in;
      end
   end

   assign cursor = cur_ff;

endmodule

>>> src/four_level_page_table_builder.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  operation, four indices, frame, read page
// rsp_      out        rsp_valid/rsp_stall  status, entry value, tables allocated, used
// csr_      in         csr_write            csr_index, csr_wdata
//
// One request at a time through a single-port table memory (one access a cycle).
// Set cursor loads the cursor; read fetches one entry; map walks, clears and links new pages, writes leaf.
// After reset a clearing pass over all POOL_PAGES*512 words runs before any request.
// A finished response waits in the output register while the next request is taken.
module four_level_page_table_builder import ptb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_operation,
   input  logic [8:0]            req_top_index,
   input  logic [8:0]            req_dir_ptr_index,
   input  logic [8:0]            req_dir_index,
   input  logic [8:0]            req_table_index,
   input  logic [39:0]           req_frame_number,
   input  logic [3:0]            req_read_page,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_status,
   output logic [63:0]           rsp_entry_value,
   output logic [1:0]            rsp_tables_allocated,
   output logic [4:0]            rsp_used_page_count,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [39:0]           csr_wdata
);

   localparam logic [3:0] S_INIT    = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_WALK_RD = 4'd2;
   localparam logic [3:0] S_WALK_CK = 4'd3;
   localparam logic [3:0] S_DECIDE  = 4'd4;
   localparam logic [3:0] S_CLR     = 4'd5;
   localparam logic [3:0] S_LINK    = 4'd6;
   localparam logic [3:0] S_LEAF    = 4'd7;
   localparam logic [3:0] S_READ    = 4'd8;
   localparam logic [3:0] S_READ_CK = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   logic [3:0]            state_ff, state_in;
   logic [ADDR_BITS-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [1:0]            lvl_ff, lvl_in;
   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic [USED_BITS-1:0]  used_ff, used_in;
   logic [FLAG_BITS-1:0]  flags_ff;
   logic [FRAME_BITS-1:0] base_ff;
   logic [4:0]            limit_ff;
   logic [1:0]            op_ff;
   logic [FRAME_BITS-1:0] frame_ff;
   logic [3:0]            rpage_ff;
   logic [IDX_BITS-1:0]   tidx_ff;
   logic                  res_status_ff, res_status_in;
   logic [WORD_BITS-1:0]  res_value_ff, res_value_in;
   logic [1:0]            res_alloc_ff, res_alloc_in;
   logic                  rsp_valid_ff;
   logic                  rsp_status_ff;
   logic [WORD_BITS-1:0]  rsp_value_ff;
   logic [1:0]            rsp_alloc_ff;
   logic [4:0]            rsp_used_ff;

   logic                  req_accept;
   logic                  rsp_load;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_addr;
   logic [WORD_BITS-1:0]  mem_wdata;
   logic [WORD_BITS-1:0]  mem_rdata;
   logic [IDX_BITS-1:0]   lvl_idx;
   logic                  entry_present;
   logic [PAGE_BITS-1:0]  entry_page;
   logic [1:0]            need;
   logic [SUM_BITS-1:0]   need_sum;
   logic                  pool_ok;
   logic [WORD_BITS-1:0]  link_word;
   logic [WORD_BITS-1:0]  leaf_word;
   cursor_cmd_type        cur_cmd;
   cursor_type            cur_load;
   cursor_type            cur;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= FLAG_BITS'(3);
         base_ff  <= '0;
         limit_ff <= 5'd16;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FLAGS: flags_ff <= csr_wdata[FLAG_BITS-1:0];
            CSR_BASE:  base_ff  <= csr_wdata;
            CSR_LIMIT: limit_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Cursor
   assign cur_load.top     = req_top_index;
   assign cur_load.dir_ptr = req_dir_ptr_index;
   assign cur_load.dir     = req_dir_index;
   assign cur_load.leaf    = req_table_index;
   assign cur_cmd.load     = req_accept && (req_operation == OP_SET);
   assign cur_cmd.advance  = (state_ff == S_LEAF);

   ptb_cursor u_cursor (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cur_cmd),
      .load_value (cur_load),
      .cursor     (cur)
   );

   // Walk decode
   always_comb begin
      case (lvl_ff)
         2'd0:    lvl_idx = cur.top;
         2'd1:    lvl_idx = cur.dir_ptr;
         default: lvl_idx = cur.dir;
      endcase
   end

   assign entry_present = |mem_rdata[51:12];
   assign entry_page    = mem_rdata[PAGE_SHIFT +: PAGE_BITS] - base_ff[PAGE_BITS-1:0];
   assign need          = 2'd3 - lvl_ff;
   assign need_sum      = SUM_BITS'(used_ff) + SUM_BITS'(need);
   assign pool_ok       = (need_sum < SUM_BITS'(limit_ff)) &&
                          (need_sum <= SUM_BITS'(POOL_PAGES));
   assign link_word     = ((WORD_BITS'(base_ff) + WORD_BITS'(used_ff)) << PAGE_SHIFT) |
                          WORD_BITS'(flags_ff);
   assign leaf_word     = (WORD_BITS'(frame_ff) << PAGE_SHIFT) | WORD_BITS'(flags_ff);

   // Memory port
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = {page_ff, lvl_idx};
      mem_wdata = '0;
      case (state_ff)
         S_INIT: begin
            mem_we   = 1'b1;
            mem_addr = clr_cnt_ff;
         end
         S_CLR: begin
            mem_we   = 1'b1;
            mem_addr = {used_ff[PAGE_BITS-1:0], clr_cnt_ff[IDX_BITS-1:0]};
         end
         S_LINK: begin
            mem_we    = 1'b1;
            mem_wdata = link_word;
         end
         S_LEAF: begin
            mem_we    = 1'b1;
            mem_addr  = {page_ff, cur.leaf};
            mem_wdata = leaf_word;
         end
         S_READ: begin
            mem_addr = {PAGE_BITS'(rpage_ff), tidx_ff};
         end
         default: ;
      endcase
   end

   ptb_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      lvl_in        = lvl_ff;
      page_in       = page_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_alloc_in  = res_alloc_ff;
      unique case (state_ff)
         S_INIT: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               res_status_in = 1'b0;
               res_value_in  = '0;
               res_alloc_in  = '0;
               lvl_in        = '0;
               page_in       = '0;
               case (req_operation)
                  OP_MAP:  state_in = S_WALK_RD;
                  OP_READ: state_in = S_READ;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_WALK_RD: state_in = S_WALK_CK;
         S_WALK_CK: begin
            if (entry_present) begin
               page_in  = entry_page;
               lvl_in   = lvl_ff + 1'b1;
               state_in = (lvl_ff == 2'd2) ? S_DECIDE : S_WALK_RD;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            clr_cnt_in = '0;
            if (need == 2'd0) begin
               state_in = S_LEAF;
            end else if (!pool_ok) begin
               res_status_in = 1'b1;
               state_in      = S_DONE;
            end else begin
               state_in = S_CLR;
            end
         end
         S_CLR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff[IDX_BITS-1:0]) begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            page_in      = used_ff[PAGE_BITS-1:0];
            used_in      = used_ff + 1'b1;
            res_alloc_in = res_alloc_ff + 1'b1;
            lvl_in       = lvl_ff + 1'b1;
            clr_cnt_in   = '0;
            state_in     = (lvl_ff == 2'd2) ? S_LEAF : S_CLR;
         end
         S_LEAF: begin
            res_value_in = leaf_word;
            state_in     = S_DONE;
         end
         S_READ: state_in = S_READ_CK;
         S_READ_CK: begin
            if (32'(rpage_ff) < POOL_PAGES) begin
               res_value_in = mem_rdata;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         clr_cnt_ff <= '0;
         lvl_ff     <= '0;
         page_ff    <= '0;
         used_ff    <= USED_BITS'(1);
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         lvl_ff     <= lvl_in;
         page_ff    <= page_in;
         used_ff    <= used_in;
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_alloc_ff  <= res_alloc_in;
      if (req_accept) begin
         op_ff    <= req_operation;
         frame_ff <= req_frame_number;
         rpage_ff <= req_read_page;
         tidx_ff  <= req_table_index;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_alloc_ff  <= res_alloc_ff;
         rsp_used_ff   <= 5'(used_ff);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_entry_value      = rsp_value_ff;
   assign rsp_tables_allocated = rsp_alloc_ff;
   assign rsp_used_page_count  = rsp_used_ff;

   // Checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_BITS'(POOL_PAGES))
      else $error("pool page count beyond pool");

   a_used_only_link: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LINK) |=> $stable(used_ff))
      else $error("page count changed outside allocation");

   a_link_in_pool: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK) |-> (32'(used_ff) < POOL_PAGES))
      else $error("allocated page outside pool");

   a_oom_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_load && res_status_ff |-> (res_alloc_ff == 2'd0) && (res_value_ff == '0)
         && (op_ff == OP_MAP))
      else $error("out-of-pool response carries data");

endmodule
